/* rtl/bct_pkg.sv */
// Shared types and constants for the birthday collision table.
package bct_pkg;

  localparam int HASH_W        = 64;
  localparam int BIRTHDAY_BITS = 50;
  localparam int IDX_LSB       = HASH_W - BIRTHDAY_BITS;
  localparam int KEY_W         = 5;
  localparam int NONCE_W       = 26;
  localparam int EARLY_W       = 27;
  localparam int ENTRY_W       = KEY_W + NONCE_W;

  typedef enum logic {
    CMD_PROBE = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic {
    SWP_IDLE = 1'b0,
    SWP_RUN  = 1'b1
  } swp_state_t;

  // status from the clearing sequencer
  typedef struct packed {
    logic busy;
    logic wr_en;
    logic report;
  } swp_stat_t;

endpackage

/* rtl/bct_mem.sv */
// Table memory: one write port, one read port with registered read data.
module bct_mem #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 31
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first: a same-edge write is not seen here
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/bct_sweep.sv */
// Clearing sequencer: zeroes every table entry after reset and on a clear request.
module bct_sweep
  import bct_pkg::*;
#(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear_req,
  output swp_stat_t         stat,
  output logic [ADDR_W-1:0] wr_addr
);

  swp_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              report_r, report_nxt;
  logic              last;

  assign last = &idx_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SWP_IDLE: if (clear_req) state_nxt = SWP_RUN;
      SWP_RUN:  if (last) state_nxt = SWP_IDLE;
      default:  state_nxt = SWP_IDLE;
    endcase
  end

  always_comb begin
    stat    = '0;
    wr_addr = idx_r;
    unique case (state_r)
      SWP_IDLE: begin
        stat = '0;
      end
      SWP_RUN: begin
        stat.busy   = 1'b1;
        stat.wr_en  = 1'b1;
        stat.report = last & report_r;
      end
      default: stat = '0;
    endcase
  end

  always_comb begin
    idx_nxt    = idx_r;
    report_nxt = report_r;
    if (state_r == SWP_RUN) begin
      idx_nxt = idx_r + 1'b1;
      if (last) report_nxt = 1'b0;
    end else if (clear_req) begin
      report_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SWP_RUN;
      idx_r    <= '0;
      report_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      report_r <= report_nxt;
    end
  end

endmodule

/* rtl/bct_probe.sv */
// Probe stage: key compare on the read entry, write-back request, result register.
module bct_probe
  import bct_pkg::*;
#(
  parameter int ADDR_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  input  logic [ADDR_W-1:0]  req_idx,
  input  logic [KEY_W-1:0]   req_key,
  input  logic [NONCE_W-1:0] req_nonce,
  input  logic [ENTRY_W-1:0] rd_data,
  input  logic               mem_wr_en,
  input  logic [ADDR_W-1:0]  mem_wr_addr,
  input  logic [ENTRY_W-1:0] mem_wr_data,
  input  logic               clear_report,
  output logic               wr_en,
  output logic [ADDR_W-1:0]  wr_addr,
  output logic [ENTRY_W-1:0] wr_data,
  output logic               out_valid,
  output logic               out_hit,
  output logic [EARLY_W-1:0] out_earlier_nonce,
  output logic [NONCE_W-1:0] out_later_nonce
);

  logic               s1_valid_r;
  logic [ADDR_W-1:0]  s1_idx_r;
  logic [KEY_W-1:0]   s1_key_r;
  logic [NONCE_W-1:0] s1_nonce_r;

  logic               lw_en_r;
  logic [ADDR_W-1:0]  lw_addr_r;
  logic [ENTRY_W-1:0] lw_data_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [EARLY_W-1:0] out_earlier_r, out_earlier_nxt;
  logic [NONCE_W-1:0] out_later_r, out_later_nxt;

  logic [ENTRY_W-1:0] entry;
  logic               hit;

  // the read was taken on the same edge as the previous write: forward it
  assign entry = (lw_en_r && lw_addr_r == s1_idx_r) ? lw_data_r : rd_data;
  assign hit   = (entry != '0) && (entry[ENTRY_W-1 -: KEY_W] == s1_key_r);

  assign wr_en   = s1_valid_r & ~hit;
  assign wr_addr = s1_idx_r;
  assign wr_data = {s1_key_r, s1_nonce_r};

  always_comb begin
    out_valid_nxt   = 1'b0;
    out_hit_nxt     = 1'b0;
    out_earlier_nxt = '0;
    out_later_nxt   = '0;
    if (s1_valid_r) begin
      out_valid_nxt = 1'b1;
      if (hit) begin
        out_hit_nxt     = 1'b1;
        out_earlier_nxt = {1'b0, entry[NONCE_W-1:0]};
        out_later_nxt   = s1_nonce_r;
      end
    end else if (clear_report) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      lw_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= req_valid;
      lw_en_r     <= mem_wr_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r      <= req_idx;
    s1_key_r      <= req_key;
    s1_nonce_r    <= req_nonce;
    lw_addr_r     <= mem_wr_addr;
    lw_data_r     <= mem_wr_data;
    out_hit_r     <= out_hit_nxt;
    out_earlier_r <= out_earlier_nxt;
    out_later_r   <= out_later_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_earlier_nonce = out_earlier_r;
  assign out_later_nonce   = out_later_r;

endmodule

/* rtl/birthday_collision_table_unit.sv */
// Birthday collision table: a probe takes one request per clock while busy is low.
// Its result strobes on out_valid once the request has passed the s1 stage register and the result register.
// The table lives in one memory with a single write port. A clear request and
// reset zero it one entry per cycle, all 2**TABLE_BITS entries (65536 by default),
// with busy high the whole time. The clear result strobes in the cycle after the
// last sweep write, the first cycle with busy low again.
// The receiver cannot stall, and results leave in request order.
module birthday_collision_table_unit
  import bct_pkg::*;
#(
  parameter int TABLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic [NONCE_W-1:0] in_nonce,
  input  logic [HASH_W-1:0]  in_hash_word,
  output logic               out_valid,
  output logic               out_hit,
  output logic [EARLY_W-1:0] out_earlier_nonce,
  output logic [NONCE_W-1:0] out_later_nonce
);

  swp_stat_t             swp_stat;
  logic [TABLE_BITS-1:0] swp_addr;

  logic                  accept;
  logic                  probe_req;
  logic                  clear_req;
  logic [TABLE_BITS-1:0] req_idx;
  logic [KEY_W-1:0]      req_key;

  logic                  pr_wr_en;
  logic [TABLE_BITS-1:0] pr_wr_addr;
  logic [ENTRY_W-1:0]    pr_wr_data;

  logic                  mem_wr_en;
  logic [TABLE_BITS-1:0] mem_wr_addr;
  logic [ENTRY_W-1:0]    mem_wr_data;
  logic [ENTRY_W-1:0]    mem_rd_data;

  assign busy      = swp_stat.busy;
  assign accept    = start & ~swp_stat.busy;
  assign probe_req = accept & (cmd_t'(in_cmd) == CMD_PROBE);
  assign clear_req = accept & (cmd_t'(in_cmd) == CMD_CLEAR);

  // key is the top five birthday bits, index the low table bits of the birthday
  assign req_key = in_hash_word[HASH_W-1 -: KEY_W];
  assign req_idx = in_hash_word[IDX_LSB +: TABLE_BITS];

  always_comb begin
    if (swp_stat.wr_en) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = swp_addr;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = pr_wr_en;
      mem_wr_addr = pr_wr_addr;
      mem_wr_data = pr_wr_data;
    end
  end

  bct_sweep #(
    .ADDR_W (TABLE_BITS)
  ) u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_req (clear_req),
    .stat      (swp_stat),
    .wr_addr   (swp_addr)
  );

  bct_mem #(
    .ADDR_W (TABLE_BITS),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (probe_req),
    .rd_addr (req_idx),
    .rd_data (mem_rd_data)
  );

  bct_probe #(
    .ADDR_W (TABLE_BITS)
  ) u_probe (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (probe_req),
    .req_idx           (req_idx),
    .req_key           (req_key),
    .req_nonce         (in_nonce),
    .rd_data           (mem_rd_data),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data),
    .clear_report      (swp_stat.report),
    .wr_en             (pr_wr_en),
    .wr_addr           (pr_wr_addr),
    .wr_data           (pr_wr_data),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_earlier_nonce (out_earlier_nonce),
    .out_later_nonce   (out_later_nonce)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for birthday_collision_table_unit: directed table, then random requests.
module tb;
  import bct_pkg::*;

  localparam int TBL_BITS     = 16;
  localparam int KEY_LSB      = HASH_W - KEY_W;
  localparam int RANDOM_ITEMS = 830;
  localparam int MAX_CLEARS   = 5;
  localparam int POOL_IDX     = 12;
  localparam int POOL_KEYS    = 6;
  localparam int STALL_LIMIT  = 4 * (1 << TBL_BITS);
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic               hit;
    logic [EARLY_W-1:0] earlier;
    logic [NONCE_W-1:0] later;
  } lookup_result_t;

  typedef struct {
    cmd_t               cmd;
    logic [NONCE_W-1:0] nonce;
    logic [HASH_W-1:0]  hash;
    bit                 typed;
    lookup_result_t     result;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_cmd;
  logic [NONCE_W-1:0] in_nonce;
  logic [HASH_W-1:0]  in_hash_word;
  logic               out_valid;
  logic               out_hit;
  logic [EARLY_W-1:0] out_earlier_nonce;
  logic [NONCE_W-1:0] out_later_nonce;

  // entries never written read as empty
  logic [31:0]    birthday_entries [int unsigned];
  lookup_result_t pending_results[$];
  stim_row_t      directed_rows[$];
  int             mismatches  = 0;
  int             idle_cycles = 0;

  birthday_collision_table_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_nonce          (in_nonce),
    .in_hash_word      (in_hash_word),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_earlier_nonce (out_earlier_nonce),
    .out_later_nonce   (out_later_nonce)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic lookup_result_t lookup_birthday(cmd_t cmd, logic [NONCE_W-1:0] nonce,
                                                     logic [HASH_W-1:0] hash);
    logic [TBL_BITS-1:0] idx;
    logic [KEY_W-1:0]    key;
    logic [31:0]         entry;
    lookup_result_t      res;
    res = '0;
    if (cmd == CMD_CLEAR) begin
      birthday_entries.delete();
      return res;
    end
    idx   = hash[IDX_LSB +: TBL_BITS];
    key   = hash[KEY_LSB +: KEY_W];
    entry = birthday_entries.exists(idx) ? birthday_entries[idx] : 32'd0;
    if (entry != 32'd0 && entry[EARLY_W +: KEY_W] == key) begin
      res.hit     = 1'b1;
      res.earlier = entry[EARLY_W-1:0];
      res.later   = nonce;
    end else begin
      birthday_entries[idx] = {key, 1'b0, nonce};
    end
    return res;
  endfunction

  function automatic logic [HASH_W-1:0] make_hash(logic [KEY_W-1:0] key,
                                                  logic [TBL_BITS-1:0] idx,
                                                  logic [HASH_W-1:0] fill);
    logic [HASH_W-1:0] h;
    h = fill;
    h[KEY_LSB +: KEY_W]    = key;
    h[IDX_LSB +: TBL_BITS] = idx;
    return h;
  endfunction

  function automatic void add_row(cmd_t cmd, logic [NONCE_W-1:0] nonce, logic [HASH_W-1:0] hash,
                                  bit typed, lookup_result_t res);
    stim_row_t row;
    row.cmd    = cmd;
    row.nonce  = nonce;
    row.hash   = hash;
    row.typed  = typed;
    row.result = res;
    directed_rows.push_back(row);
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // holds the request until the block takes it, then books the expected result
  task automatic send_request(cmd_t cmd, logic [NONCE_W-1:0] nonce, logic [HASH_W-1:0] hash,
                              bit typed, lookup_result_t typed_res, int gap);
    lookup_result_t predicted;
    @(negedge clk);
    start        = 1'b1;
    in_cmd       = cmd;
    in_nonce     = nonce;
    in_hash_word = hash;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = lookup_birthday(cmd, nonce, hash);
    pending_results.push_back(typed ? typed_res : predicted);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", out_hit, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
        if (out_earlier_nonce !== want.earlier)
          report_mismatch("earlier_nonce", out_earlier_nonce, want.earlier);
        if (out_later_nonce !== want.later)
          report_mismatch("later_nonce", out_later_nonce, want.later);
      end
    end
  end

  // a clear sweep is the longest legal stretch without a handshake
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("birthday_collision_table_unit verification failed");
      $finish;
    end
  end

  initial begin
    lookup_result_t      miss;
    logic [TBL_BITS-1:0] idx_pool [POOL_IDX];
    logic [KEY_W-1:0]    key_pool [POOL_KEYS];
    logic [NONCE_W-1:0]  nonce;
    logic [HASH_W-1:0]   hash;
    logic [TBL_BITS-1:0] idx;
    cmd_t                cmd;
    int                  clears_left;
    int                  sel;
    bit                  no_idle;
    miss         = '0;
    clears_left  = MAX_CLEARS;
    no_idle      = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = CMD_PROBE;
    in_nonce     = '0;
    in_hash_word = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // empty table, zero key, extremes of nonce and hash
    add_row(CMD_PROBE, '0, make_hash('0, '0, '0), 1'b1, miss);
    add_row(CMD_PROBE, '1, make_hash('0, '0, '0), 1'b1, miss);
    add_row(CMD_PROBE, 26'd1, make_hash('0, '0, '1), 1'b1, '{1'b1, 27'h3FFFFFF, 26'd1});
    add_row(CMD_PROBE, '1, '1, 1'b1, miss);
    add_row(CMD_PROBE, '0, '1, 1'b1, '{1'b1, 27'h3FFFFFF, 26'd0});
    // key mismatch overwrites the entry
    add_row(CMD_PROBE, 26'h12345, make_hash(5'd30, '1, '0), 1'b0, miss);
    add_row(CMD_PROBE, 26'h777, make_hash(5'd31, '1, '0), 1'b0, miss);
    add_row(CMD_PROBE, 26'h55, make_hash(5'd30, '1, '1), 1'b0, miss);
    add_row(CMD_PROBE, '0, make_hash('0, '0, '0), 1'b0, miss);
    // nonce zero with key zero leaves an entry that reads as empty
    add_row(CMD_PROBE, '0, make_hash('0, 16'h1234, '1), 1'b0, miss);
    add_row(CMD_PROBE, 26'd9, make_hash('0, 16'h1234, '0), 1'b0, miss);
    add_row(CMD_PROBE, 26'd10, make_hash('0, 16'h1234, '0), 1'b0, miss);
    // birthday bits outside index and key must not matter
    add_row(CMD_PROBE, 26'h2AAAAAA, make_hash(5'd5, 16'h00AA, {16{4'h5}}), 1'b0, miss);
    add_row(CMD_PROBE, 26'h1555555, make_hash(5'd5, 16'h00AA, {16{4'hA}}), 1'b0, miss);
    add_row(CMD_CLEAR, '1, '1, 1'b1, miss);
    add_row(CMD_PROBE, 26'd4, '1, 1'b1, miss);
    add_row(CMD_PROBE, 26'd8, make_hash('0, '0, '0), 1'b1, miss);
    add_row(CMD_PROBE, 26'd9, make_hash('0, '0, '0), 1'b1, '{1'b1, 27'd8, 26'd9});
    add_row(CMD_PROBE, 26'h2AAAAAA, {16{4'hA}}, 1'b0, miss);
    add_row(CMD_PROBE, 26'h1555555, {16{4'h5}}, 1'b0, miss);
    add_row(CMD_PROBE, '1, '1, 1'b0, miss);

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].nonce, directed_rows[i].hash,
                   directed_rows[i].typed, directed_rows[i].result, idle_gap());

    // small pools of slots and keys so that lookups revisit entries and collide
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        foreach (idx_pool[i]) idx_pool[i] = TBL_BITS'($urandom_range(0, (1 << TBL_BITS) - 1));
        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, 31));
      end
      if (n % 64 == 0) no_idle = ($urandom_range(0, 2) == 0);
      sel   = $urandom_range(0, 99);
      cmd   = CMD_PROBE;
      nonce = NONCE_W'($urandom);
      hash  = {$urandom, $urandom};
      idx   = idx_pool[$urandom_range(0, POOL_IDX - 1)];
      if (sel == 0 && clears_left > 0) begin
        cmd = CMD_CLEAR;
        clears_left--;
      end else if (sel < 5) begin
        nonce = '0;
        hash  = make_hash('0, idx, hash);
      end else if (sel < 80) begin
        hash = make_hash(key_pool[$urandom_range(0, POOL_KEYS - 1)], idx, hash);
      end else if (sel < 92) begin
        hash = make_hash(KEY_W'($urandom_range(0, 31)), idx, hash);
      end
      send_request(cmd, nonce, hash, 1'b0, miss, no_idle ? 0 : idle_gap());
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("birthday_collision_table_unit verification clean");
    end else begin
      $display("birthday_collision_table_unit verification failed");
    end
    $finish;
  end

endmodule
